[hw/rtl/csl_pkg.sv]
package csl_pkg;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_FLASH_RX = 3'd1,
		OP_FLASH_TX = 3'd2,
		OP_IDENTIFY = 3'd3,
		OP_SET_TX   = 3'd4,
		OP_SLEEP    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		REG_FLASH_ON  = 2'd0,
		REG_FLASH_OFF = 2'd1,
		REG_IDENTIFY  = 2'd2
	} reg_idx_t;

	localparam int unsigned CFG_W  = 16;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned OUT_W  = 2;

	localparam logic [CFG_W-1:0] FLASH_ON_RST  = 16'd15;
	localparam logic [CFG_W-1:0] FLASH_OFF_RST = 16'd40;
	localparam logic [CFG_W-1:0] IDENTIFY_RST  = 16'd80;

	localparam logic [1:0] PHASE_TX_ON = 2'd1;
	localparam logic [1:0] PHASE_RX_ON = 2'd3;

	typedef struct packed {
		logic [CFG_W-1:0] flash_on_ms;
		logic [CFG_W-1:0] flash_off_ms;
		logic [CFG_W-1:0] identify_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [TIME_W-1:0] now_ms;
		logic              identify_on;
		logic              tx_level;
		logic              bus_off;
		logic              app_error;
		logic              bus_open;
	} req_t;

endpackage

[hw/rtl/can_status_led_controller.sv]
// CAN status LED controller: keeps one Rx and one Tx LED level per channel and answers every
// request transfer with one transfer carrying the levels of channels 0 and 1. A request is
// registered on input, then one pass of per-channel compare-and-update logic writes the channel
// state and the result register together, so one request is taken per clock while the output is
// not stalled, and its result is presented from that register. At reset all LEDs are on with
// flash on/off/identify times of 15/40/80 ms; configuration writes take effect at once.
module can_status_led_controller #(
	parameter int CHANNELS = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] req_type,
	input  logic       channel,
	input  logic [31:0] now_ms,
	input  logic       identify_on,
	input  logic       tx_level,
	input  logic       bus_off,
	input  logic       app_error,
	input  logic       bus_open,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] rx_leds,
	output logic [1:0] tx_leds
);
	import csl_pkg::*;

	cfg_t              cfg_q;
	logic              valid_s1;
	req_t              req_s1;
	logic              ch_s1;
	logic              advance, go;
	logic [CHANNELS-1:0] sel;
	logic [CHANNELS-1:0] rx_lvl_d, tx_lvl_d;
	logic [OUT_W-1:0]  rx_view, tx_view;
	logic              out_valid_q;
	logic [OUT_W-1:0]  rx_leds_q, tx_leds_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flash_on_ms  <= FLASH_ON_RST;
			cfg_q.flash_off_ms <= FLASH_OFF_RST;
			cfg_q.identify_ms  <= IDENTIFY_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FLASH_ON:  cfg_q.flash_on_ms  <= cfg_data;
				REG_FLASH_OFF: cfg_q.flash_off_ms <= cfg_data;
				REG_IDENTIFY:  cfg_q.identify_ms  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign go       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1.op          <= req_type;
			req_s1.now_ms      <= now_ms;
			req_s1.identify_on <= identify_on;
			req_s1.tx_level    <= tx_level;
			req_s1.bus_off     <= bus_off;
			req_s1.app_error   <= app_error;
			req_s1.bus_open    <= bus_open;
			ch_s1              <= channel;
		end
	end

	for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
		assign sel[k] = go && (32'(ch_s1) == k);
		csl_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.go       (go),
			.sel      (sel[k]),
			.req      (req_s1),
			.cfg      (cfg_q),
			.rx_lvl_d (rx_lvl_d[k]),
			.tx_lvl_d (tx_lvl_d[k])
		);
	end

	for (genvar k = 0; k < OUT_W; k++) begin : g_view
		if (k < CHANNELS) begin : g_on
			assign rx_view[k] = rx_lvl_d[k];
			assign tx_view[k] = tx_lvl_d[k];
		end else begin : g_off
			assign rx_view[k] = 1'b0;
			assign tx_view[k] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rx_leds_q <= rx_view;
			tx_leds_q <= tx_view;
		end
	end

	assign out_valid = out_valid_q;
	assign rx_leds   = rx_leds_q;
	assign tx_leds   = tx_leds_q;

endmodule

[hw/rtl/csl_lane.sv]
module csl_lane (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic          sel,
	input  csl_pkg::req_t req,
	input  csl_pkg::cfg_t cfg,
	output logic          rx_lvl_d,
	output logic          tx_lvl_d
);
	import csl_pkg::*;

	logic              ident_q, ident_d;
	logic [TIME_W-1:0] blink_q, blink_d;
	logic [1:0]        phase_q, phase_d;
	logic [TIME_W-1:0] rx_on_q, rx_on_d, rx_off_q, rx_off_d;
	logic [TIME_W-1:0] tx_on_q, tx_on_d, tx_off_q, tx_off_d;
	logic              rx_fl_q, rx_fl_d, tx_fl_q, tx_fl_d;
	logic              err_q, err_d;
	logic              rx_lvl_q, tx_lvl_q;

	logic [TIME_W-1:0] blink_lag, rx_run, tx_run, rx_rest, tx_rest;
	logic [TIME_W-1:0] on_ext, off_ext, id_ext;
	logic [1:0]        phase_inc;

	assign blink_lag = req.now_ms - blink_q;
	assign rx_run    = req.now_ms - rx_on_q;
	assign tx_run    = req.now_ms - tx_on_q;
	assign rx_rest   = req.now_ms - rx_off_q;
	assign tx_rest   = req.now_ms - tx_off_q;
	assign on_ext    = {{(TIME_W-CFG_W){1'b0}}, cfg.flash_on_ms};
	assign off_ext   = {{(TIME_W-CFG_W){1'b0}}, cfg.flash_off_ms};
	assign id_ext    = {{(TIME_W-CFG_W){1'b0}}, cfg.identify_ms};
	assign phase_inc = phase_q + 2'd1;

	always_comb begin
		ident_d  = ident_q;
		blink_d  = blink_q;
		phase_d  = phase_q;
		rx_on_d  = rx_on_q;
		rx_off_d = rx_off_q;
		tx_on_d  = tx_on_q;
		tx_off_d = tx_off_q;
		rx_fl_d  = rx_fl_q;
		tx_fl_d  = tx_fl_q;
		err_d    = err_q;
		rx_lvl_d = rx_lvl_q;
		tx_lvl_d = tx_lvl_q;
		if (go && req.op == OP_SLEEP) begin
			rx_lvl_d = 1'b0;
			tx_lvl_d = 1'b0;
		end else if (sel) begin
			case (req.op)
				OP_TICK: begin
					if (ident_q) begin
						// wrap-safe "now has reached next blink"
						if (!blink_lag[TIME_W-1]) begin
							phase_d  = phase_inc;
							tx_lvl_d = (phase_inc == PHASE_TX_ON);
							rx_lvl_d = (phase_inc == PHASE_RX_ON);
							blink_d  = blink_q + id_ext;
						end
					end else if (req.bus_off || req.app_error) begin
						rx_lvl_d = 1'b1;
						tx_lvl_d = 1'b1;
						err_d    = 1'b1;
					end else begin
						if (err_q) begin
							rx_lvl_d = 1'b0;
							tx_lvl_d = 1'b0;
							err_d    = 1'b0;
						end
						if (rx_fl_q && rx_run > on_ext) begin
							rx_lvl_d = 1'b0;
							rx_fl_d  = 1'b0;
							rx_off_d = req.now_ms;
						end
						if (tx_fl_q && tx_run > on_ext) begin
							tx_lvl_d = 1'b0;
							tx_fl_d  = 1'b0;
							tx_off_d = req.now_ms;
						end
						if (!req.bus_open)
							tx_lvl_d = 1'b1;
					end
				end
				OP_FLASH_RX: begin
					if (!ident_q && !rx_fl_q && rx_rest > off_ext) begin
						rx_lvl_d = 1'b1;
						rx_fl_d  = 1'b1;
						rx_on_d  = req.now_ms;
					end
				end
				OP_FLASH_TX: begin
					if (!ident_q && !tx_fl_q && tx_rest > off_ext) begin
						tx_lvl_d = 1'b1;
						tx_fl_d  = 1'b1;
						tx_on_d  = req.now_ms;
					end
				end
				OP_IDENTIFY: begin
					if (ident_q != req.identify_on) begin
						ident_d  = req.identify_on;
						blink_d  = req.now_ms + id_ext;
						rx_lvl_d = req.identify_on;
						tx_lvl_d = req.identify_on;
					end
				end
				OP_SET_TX: begin
					if (!ident_q)
						tx_lvl_d = req.tx_level;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q  <= 1'b0;
			blink_q  <= '0;
			phase_q  <= '0;
			rx_on_q  <= '0;
			rx_off_q <= '0;
			tx_on_q  <= '0;
			tx_off_q <= '0;
			rx_fl_q  <= 1'b0;
			tx_fl_q  <= 1'b0;
			err_q    <= 1'b0;
			rx_lvl_q <= 1'b1;
			tx_lvl_q <= 1'b1;
		end else if (go) begin
			ident_q  <= ident_d;
			blink_q  <= blink_d;
			phase_q  <= phase_d;
			rx_on_q  <= rx_on_d;
			rx_off_q <= rx_off_d;
			tx_on_q  <= tx_on_d;
			tx_off_q <= tx_off_d;
			rx_fl_q  <= rx_fl_d;
			tx_fl_q  <= tx_fl_d;
			err_q    <= err_d;
			rx_lvl_q <= rx_lvl_d;
			tx_lvl_q <= tx_lvl_d;
		end
	end

endmodule

[hw/rtl/csl_checker.sv]
module csl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [2:0] req_type,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] rx_leds,
	input logic [1:0] tx_leds
);
	import csl_pkg::*;

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output is free");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("accepted request produced no result");

	a_sleep_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && req_type == OP_SLEEP) ##1 (!out_valid || !out_stall)
		|=> out_valid && rx_leds == 2'b00 && tx_leds == 2'b00)
		else $error("sleep left an LED on");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rx_leds) && $stable(tx_leds))
		else $error("stalled result changed");

endmodule

bind can_status_led_controller csl_checker u_csl_checker (.*);

[bench/tb_can_status_led_controller.sv]
module tb_can_status_led_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import csl_pkg::*;

	localparam int CHANNELS   = 2;
	localparam int DIR_N      = 27;
	localparam int PHASES     = 6;
	localparam int PHASE_ITEMS = 75;
	localparam int TAIL_CYCLES = 8;
	localparam int IDLE_LIMIT  = 1000;

	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	typedef struct packed {
		logic [2:0]  op;
		logic        ch;
		logic [31:0] now;
		logic        ident;
		logic        txl;
		logic        boff;
		logic        aerr;
		logic        bopen;
		logic        chk;
		logic [1:0]  rx;
		logic [1:0]  tx;
	} led_req_t;

	typedef struct packed {
		logic [1:0] rx;
		logic [1:0] tx;
	} led_levels_t;

	// op, ch, now, ident, txl, boff, aerr, bopen, chk, rx, tx
	localparam led_req_t DIR_TAB [DIR_N] = '{
		'{OP_TICK,     1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 2'd3, 2'd3},
		'{OP_SLEEP,    1'b1, 32'd0,          1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 2'd0, 2'd0},
		'{OP_FLASH_RX, 1'b0, 32'd100,        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_FLASH_RX, 1'b0, 32'd101,        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_TICK,     1'b0, 32'd116,        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_FLASH_RX, 1'b0, 32'd150,        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_FLASH_TX, 1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_TICK,     1'b1, 32'h0000_000F,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_TICK,     1'b0, 32'd200,        1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_TICK,     1'b0, 32'd201,        1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_TICK,     1'b0, 32'd202,        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_TICK,     1'b0, 32'd203,        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_SET_TX,   1'b0, 32'd204,        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_SET_TX,   1'b1, 32'd205,        1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_IDENTIFY, 1'b1, 32'd1000,       1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_IDENTIFY, 1'b1, 32'd1001,       1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_FLASH_RX, 1'b1, 32'd1002,       1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_SET_TX,   1'b1, 32'd1003,       1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_TICK,     1'b1, 32'd1079,       1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_TICK,     1'b1, 32'd1080,       1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_TICK,     1'b1, 32'd1160,       1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_TICK,     1'b1, 32'd1240,       1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_TICK,     1'b1, 32'd1320,       1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_IDENTIFY, 1'b1, 32'd1400,       1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_RSVD6,    1'b0, 32'h8000_0000,  1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 2'd0, 2'd0},
		'{OP_RSVD7,    1'b1, 32'h7FFF_FFFF,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_SLEEP,    1'b0, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 2'd0, 2'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  req_type = '0;
	logic        channel = 1'b0;
	logic [31:0] now_ms = '0;
	logic        identify_on = 1'b0;
	logic        tx_level = 1'b0;
	logic        bus_off = 1'b0;
	logic        app_error = 1'b0;
	logic        bus_open = 1'b1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  rx_leds;
	logic [1:0]  tx_leds;

	can_status_led_controller #(.CHANNELS(CHANNELS)) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.channel     (channel),
		.now_ms      (now_ms),
		.identify_on (identify_on),
		.tx_level    (tx_level),
		.bus_off     (bus_off),
		.app_error   (app_error),
		.bus_open    (bus_open),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.rx_leds     (rx_leds),
		.tx_leds     (tx_leds)
	);

	// predicted LED controller state
	logic [15:0] cfg_on_ms;
	logic [15:0] cfg_off_ms;
	logic [15:0] cfg_ident_ms;
	logic        ident_mode [CHANNELS];
	logic [31:0] blink_due  [CHANNELS];
	logic [1:0]  blink_ph   [CHANNELS];
	logic [31:0] rx_on_t    [CHANNELS];
	logic [31:0] rx_off_t   [CHANNELS];
	logic [31:0] tx_on_t    [CHANNELS];
	logic [31:0] tx_off_t   [CHANNELS];
	logic        rx_busy    [CHANNELS];
	logic        tx_busy    [CHANNELS];
	logic        err_shown  [CHANNELS];
	logic        rx_lvl     [CHANNELS];
	logic        tx_lvl     [CHANNELS];

	led_levels_t led_levels_q [$];

	int n_sent;
	int n_checked;
	int n_errs;
	int n_flashes;
	int n_blinks;
	int n_err_shows;
	int idle_cnt;
	int stall_cnt;
	logic [15:0] stall_pat = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic led_model_step(input led_req_t r, output led_levels_t lv);
		int unsigned c;
		logic [31:0] dt;
		c = {31'd0, r.ch};
		case (r.op)
			OP_SLEEP: begin
				for (int k = 0; k < CHANNELS; k++) begin
					rx_lvl[k] = 1'b0;
					tx_lvl[k] = 1'b0;
				end
			end
			OP_TICK: begin
				if (ident_mode[c]) begin
					dt = r.now - blink_due[c];
					if (!dt[31]) begin
						blink_ph[c]  = blink_ph[c] + 2'd1;
						tx_lvl[c]    = (blink_ph[c] == PHASE_TX_ON);
						rx_lvl[c]    = (blink_ph[c] == PHASE_RX_ON);
						blink_due[c] = blink_due[c] + {16'd0, cfg_ident_ms};
						n_blinks++;
					end
				end else if (r.boff || r.aerr) begin
					rx_lvl[c]    = 1'b1;
					tx_lvl[c]    = 1'b1;
					err_shown[c] = 1'b1;
					n_err_shows++;
				end else begin
					if (err_shown[c]) begin
						rx_lvl[c]    = 1'b0;
						tx_lvl[c]    = 1'b0;
						err_shown[c] = 1'b0;
					end
					if (rx_busy[c] && (r.now - rx_on_t[c]) > {16'd0, cfg_on_ms}) begin
						rx_lvl[c]   = 1'b0;
						rx_busy[c]  = 1'b0;
						rx_off_t[c] = r.now;
					end
					if (tx_busy[c] && (r.now - tx_on_t[c]) > {16'd0, cfg_on_ms}) begin
						tx_lvl[c]   = 1'b0;
						tx_busy[c]  = 1'b0;
						tx_off_t[c] = r.now;
					end
					if (!r.bopen)
						tx_lvl[c] = 1'b1;
				end
			end
			OP_FLASH_RX: begin
				if (!ident_mode[c] && !rx_busy[c] &&
						(r.now - rx_off_t[c]) > {16'd0, cfg_off_ms}) begin
					rx_lvl[c]  = 1'b1;
					rx_busy[c] = 1'b1;
					rx_on_t[c] = r.now;
					n_flashes++;
				end
			end
			OP_FLASH_TX: begin
				if (!ident_mode[c] && !tx_busy[c] &&
						(r.now - tx_off_t[c]) > {16'd0, cfg_off_ms}) begin
					tx_lvl[c]  = 1'b1;
					tx_busy[c] = 1'b1;
					tx_on_t[c] = r.now;
					n_flashes++;
				end
			end
			OP_IDENTIFY: begin
				if (ident_mode[c] != r.ident) begin
					ident_mode[c] = r.ident;
					blink_due[c]  = r.now + {16'd0, cfg_ident_ms};
					rx_lvl[c]     = r.ident;
					tx_lvl[c]     = r.ident;
				end
			end
			OP_SET_TX: begin
				if (!ident_mode[c])
					tx_lvl[c] = r.txl;
			end
			default: ;
		endcase
		for (int k = 0; k < 2; k++) begin
			lv.rx[k] = (k < CHANNELS) ? rx_lvl[k] : 1'b0;
			lv.tx[k] = (k < CHANNELS) ? tx_lvl[k] : 1'b0;
		end
	endtask

	// one request transfer; the valid stays up if the caller sends again right away
	task automatic send_req(input led_req_t r);
		led_levels_t lv;
		in_valid    <= 1'b1;
		req_type    <= r.op;
		channel     <= r.ch;
		now_ms      <= r.now;
		identify_on <= r.ident;
		tx_level    <= r.txl;
		bus_off     <= r.boff;
		app_error   <= r.aerr;
		bus_open    <= r.bopen;
		do @(posedge clk); while (in_stall);
		n_sent++;
		led_model_step(r, lv);
		if (r.chk) begin
			lv.rx = r.rx;
			lv.tx = r.tx;
		end
		led_levels_q.push_back(lv);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (led_levels_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(input logic [15:0] on_v, input logic [15:0] off_v,
			input logic [15:0] id_v);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_FLASH_ON;
		cfg_data <= on_v;
		@(posedge clk);
		cfg_idx  <= REG_FLASH_OFF;
		cfg_data <= off_v;
		@(posedge clk);
		cfg_idx  <= REG_IDENTIFY;
		cfg_data <= id_v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		cfg_on_ms    = on_v;
		cfg_off_ms   = off_v;
		cfg_ident_ms = id_v;
	endtask

	// receiver stall pattern, reshuffled at random; bit 0 clear bounds a stall run
	always @(posedge clk) begin
		logic [15:0] p;
		stall_cnt <= stall_cnt + 1;
		out_stall <= stall_pat[stall_cnt % 16];
		if (stall_cnt % 64 == 63) begin
			case ($urandom_range(0, 3))
				0: p = '0;
				1: p = 16'($urandom & $urandom);
				2: p = 16'($urandom | $urandom);
				default: p = 16'($urandom);
			endcase
			p[0] = 1'b0;
			stall_pat <= p;
		end
	end

	always @(posedge clk) begin
		led_levels_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_checked++;
			if (led_levels_q.size() == 0) begin
				$display("%0t: unexpected result transfer rx_leds=%b tx_leds=%b",
					$time, rx_leds, tx_leds);
				n_errs++;
			end else begin
				e = led_levels_q.pop_front();
				if (rx_leds !== e.rx) begin
					$display("%0t: rx_leds expected %b actual %b", $time, e.rx, rx_leds);
					n_errs++;
				end
				if (tx_leds !== e.tx) begin
					$display("%0t: tx_leds expected %b actual %b", $time, e.tx, tx_leds);
					n_errs++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, IDLE_LIMIT, led_levels_q.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		led_req_t    r;
		int          burst_left;
		int          gap;
		int          pick;
		logic [31:0] clk_ms;
		logic [31:0] step_max;
		logic [15:0] s_on;
		logic [15:0] s_off;
		logic [15:0] s_id;

		stall_cnt   = 0;
		idle_cnt    = 0;
		n_sent      = 0;
		n_checked   = 0;
		n_errs      = 0;
		n_flashes   = 0;
		n_blinks    = 0;
		n_err_shows = 0;
		burst_left  = 0;
		cfg_on_ms    = FLASH_ON_RST;
		cfg_off_ms   = FLASH_OFF_RST;
		cfg_ident_ms = IDENTIFY_RST;
		for (int k = 0; k < CHANNELS; k++) begin
			ident_mode[k] = 1'b0;
			blink_due[k]  = '0;
			blink_ph[k]   = '0;
			rx_on_t[k]    = '0;
			rx_off_t[k]   = '0;
			tx_on_t[k]    = '0;
			tx_off_t[k]   = '0;
			rx_busy[k]    = 1'b0;
			tx_busy[k]    = 1'b0;
			err_shown[k]  = 1'b0;
			rx_lvl[k]     = 1'b1;
			tx_lvl[k]     = 1'b1;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_req(DIR_TAB[i]);
		drain_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			clk_ms = $urandom;
			case (ph)
				0: begin
					s_on = 16'd1; s_off = 16'd0; s_id = 16'd1;
					clk_ms = 32'hFFFF_FF00;
				end
				1: begin
					s_on = 16'hFFFF; s_off = 16'hFFFF; s_id = 16'hFFFF;
				end
				2: begin
					s_on = FLASH_ON_RST; s_off = FLASH_OFF_RST; s_id = IDENTIFY_RST;
				end
				3: begin
					s_on  = 16'($urandom_range(1, 300));
					s_off = 16'($urandom_range(0, 300));
					s_id  = 16'($urandom_range(1, 300));
				end
				4: begin
					s_on = 16'd3; s_off = 16'hFFFF; s_id = 16'd2;
				end
				default: begin
					s_on = 16'hFFFF; s_off = 16'd0; s_id = 16'd9;
				end
			endcase
			write_settings(s_on, s_off, s_id);
			step_max = {16'd0, s_on};
			if ({16'd0, s_off} > step_max) step_max = {16'd0, s_off};
			if ({16'd0, s_id} > step_max) step_max = {16'd0, s_id};
			step_max = step_max / 3 + 2;

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 12);
					gap = $urandom_range(0, 6);
					if (gap != 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				burst_left--;

				if ($urandom_range(0, 31) == 0)
					clk_ms = $urandom;
				else
					clk_ms = clk_ms + $urandom_range(0, step_max);
				pick = $urandom_range(0, 99);
				if (pick < 40)      r.op = OP_TICK;
				else if (pick < 55) r.op = OP_FLASH_RX;
				else if (pick < 70) r.op = OP_FLASH_TX;
				else if (pick < 78) r.op = OP_IDENTIFY;
				else if (pick < 88) r.op = OP_SET_TX;
				else if (pick < 94) r.op = OP_SLEEP;
				else if (pick < 97) r.op = OP_RSVD6;
				else                r.op = OP_RSVD7;
				r.ch    = 1'($urandom_range(0, 1));
				r.now   = clk_ms;
				r.ident = 1'($urandom_range(0, 1));
				r.txl   = 1'($urandom_range(0, 1));
				r.boff  = ($urandom_range(0, 9) == 0);
				r.aerr  = ($urandom_range(0, 9) == 0);
				r.bopen = ($urandom_range(0, 7) != 0);
				r.chk   = 1'b0;
				r.rx    = '0;
				r.tx    = '0;
				send_req(r);
			end
			drain_results();
		end

		$display("Sent %0d requests (%0d from the directed table) over %0d timing settings;",
			n_sent, DIR_N, PHASES + 1);
		$display("checked %0d LED results, %0d flashes, %0d blink steps, %0d error displays.",
			n_checked, n_flashes, n_blinks, n_err_shows);
		if (n_errs == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/csl_pkg.sv
hw/rtl/csl_lane.sv
hw/rtl/can_status_led_controller.sv
hw/rtl/csl_checker.sv
bench/tb_can_status_led_controller.sv
